/* hdl/ctn_pkg.sv */
// shared constants, register codes and controller/datapath types
// for the coefficient threshold and norm block; no dependencies
package ctn_pkg;

  localparam int VORTEX_MAX_DEF = 32;
  localparam int FLUX_TERMS     = 3;
  localparam int COEFF_W        = 32;
  localparam int INDEX_W        = 6;
  localparam int RATIO_W        = 16;
  localparam int SUM_W          = 64;
  localparam int ROOT_W         = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_EN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_VORTEX = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_RST       = '0;
  localparam logic               THR_EN_RST      = 1'b1;
  localparam logic               NORM_VORTEX_RST = 1'b0;

  typedef struct packed {
    logic mem_wr;
    logic max_upd;
    logic sum_clr;
    logic sum_rd;
    logic emit_rd;
    logic root_start;
    logic out_load;
    logic out_last;
    logic frame_clr;
  } ctn_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic root_done;
  } ctn_stat_t;

endpackage

/* hdl/ctn_if.sv */
// request channels of the coefficient threshold and norm block
// depends on ctn_pkg
interface ctn_in_if
  import ctn_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] coeff_value;
  logic                      frame_last;

  modport source(output valid, coeff_value, frame_last, input ready);
  modport sink(input valid, coeff_value, frame_last, output ready);
endinterface

interface ctn_out_if
  import ctn_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] coeff_out;
  logic [INDEX_W-1:0]        coeff_index;
  logic                      is_flux;
  logic                      result_last;
  logic [ROOT_W-1:0]         norm_value;

  modport source(output valid, coeff_out, coeff_index, is_flux, result_last, norm_value,
                 input ready);
  modport sink(input valid, coeff_out, coeff_index, is_flux, result_last, norm_value,
               output ready);
endinterface

/* hdl/ctn_sqrt.sv */
// bit-pair integer square root, one result bit per cycle
// depends on ctn_pkg
module ctn_sqrt
  import ctn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int STEP_W = $clog2(ROOT_W);

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  res;
  logic [SUM_W-1:0]  bitv;
  logic [SUM_W-1:0]  trial;
  logic [STEP_W-1:0] step;
  logic              busy;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        res  <= '0;
        bitv <= SUM_W'(1) << (SUM_W - 2);
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        step <= step + 1'b1;
        if (step == STEP_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/ctn_dp.sv */
// datapath: coefficient store, max tracking, threshold, sum of squares,
// square root and result register; depends on ctn_pkg and ctn_sqrt
module ctn_dp
  import ctn_pkg::*;
#(
  parameter int DEPTH  = FLUX_TERMS + VORTEX_MAX_DEF,
  parameter int ADDR_W = $clog2(FLUX_TERMS + VORTEX_MAX_DEF)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctn_cmd_t                  cmd,
  output ctn_stat_t                 stat,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [ADDR_W-1:0]         rd_addr,
  input  logic signed [COEFF_W-1:0] in_coeff,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  output logic signed [COEFF_W-1:0] coeff_out,
  output logic [INDEX_W-1:0]        coeff_index,
  output logic                      is_flux,
  output logic                      result_last,
  output logic [ROOT_W-1:0]         norm_value
);

  localparam int LIMIT_W = COEFF_W + RATIO_W;

  function automatic logic [COEFF_W-1:0] magnitude(input logic [COEFF_W-1:0] v);
    return v[COEFF_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [COEFF_W-1:0] mem [DEPTH];
  logic [COEFF_W-1:0] rdata;
  logic [ADDR_W-1:0]  rd_idx;
  logic               s1_valid;
  logic               s2_valid;
  logic               s3_valid;

  logic [RATIO_W-1:0] ratio;
  logic               thr_en;
  logic               vortex_only;

  logic [COEFF_W-1:0] max_mag;
  logic [COEFF_W-1:0] in_mag;
  logic [LIMIT_W-1:0] limit;

  logic [COEFF_W-1:0] rd_mag;
  logic               rd_vortex;
  logic               pruned;
  logic [COEFF_W-1:0] norm_mag;
  logic [COEFF_W-1:0] m1;
  logic [SUM_W-1:0]   sq;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W:0]     sum_ext;
  logic [ROOT_W-1:0]  root;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio       <= RATIO_RST;
      thr_en      <= THR_EN_RST;
      vortex_only <= NORM_VORTEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATIO:       ratio       <= cfg_wdata[RATIO_W-1:0];
        CFG_THR_EN:      thr_en      <= cfg_wdata[0];
        CFG_NORM_VORTEX: vortex_only <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= in_coeff;
    end
    if (cmd.sum_rd || cmd.emit_rd) begin
      rdata  <= mem[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  // largest vortex magnitude and threshold limit
  assign in_mag = magnitude(in_coeff);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_mag <= '0;
    end else if (cmd.frame_clr) begin
      max_mag <= '0;
    end else if (cmd.max_upd && (in_mag > max_mag)) begin
      max_mag <= in_mag;
    end
  end

  always_ff @(posedge clk) begin
    limit <= LIMIT_W'(max_mag) * LIMIT_W'(ratio);
  end

  // threshold decision on the read word
  assign rd_mag    = magnitude(rdata);
  assign rd_vortex = rd_idx >= ADDR_W'(FLUX_TERMS);
  assign pruned    = rd_vortex && thr_en && ({1'b0, rd_mag, 15'b0} < limit);
  assign norm_mag  = (pruned || (!rd_vortex && vortex_only)) ? '0 : rd_mag;

  // square and saturating accumulate
  assign sum_ext = {1'b0, sum} + {1'b0, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.sum_rd;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1 <= norm_mag;
    sq <= SUM_W'(m1) * SUM_W'(m1);
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (s3_valid) begin
      sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end
  end

  ctn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (sum),
    .root     (root),
    .done     (stat.root_done)
  );

  assign stat.pipe_busy = s1_valid || s2_valid || s3_valid;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      coeff_out   <= pruned ? '0 : rdata;
      coeff_index <= INDEX_W'(rd_idx);
      is_flux     <= !rd_vortex;
      result_last <= cmd.out_last;
      norm_value  <= cmd.out_last ? root : '0;
    end
  end

endmodule

/* hdl/ctn_ctrl.sv */
// controller: load, sum pass, square root wait and emit sequencing
// depends on ctn_pkg
module ctn_ctrl
  import ctn_pkg::*;
#(
  parameter int DEPTH  = FLUX_TERMS + VORTEX_MAX_DEF,
  parameter int ADDR_W = $clog2(FLUX_TERMS + VORTEX_MAX_DEF),
  parameter int CNT_W  = $clog2(FLUX_TERMS + VORTEX_MAX_DEF + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_frame_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ctn_cmd_t          cmd,
  input  ctn_stat_t         stat,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ADDR_W-1:0] rd_addr
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SUM,
    S_DRAIN,
    S_ROOT,
    S_FETCH,
    S_EMIT
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  total;
  logic [ADDR_W-1:0] k;

  logic accept;
  logic out_take;
  logic has_room;
  logic last_item;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EMIT);
  assign accept    = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;
  assign has_room  = count < CNT_W'(DEPTH);
  assign last_item = (CNT_W'(k) + CNT_W'(1)) == total;
  assign wr_addr   = count[ADDR_W-1:0];
  assign rd_addr   = (state == S_EMIT) ? k + 1'b1 : k;

  always_comb begin
    cmd            = '0;
    cmd.mem_wr     = accept && has_room;
    cmd.max_upd    = accept && has_room && (count >= CNT_W'(FLUX_TERMS));
    cmd.sum_clr    = accept && in_frame_last;
    cmd.sum_rd     = (state == S_SUM);
    cmd.emit_rd    = ((state == S_ROOT) && stat.root_done)
                     || (out_take && !last_item);
    cmd.root_start = (state == S_DRAIN) && !stat.pipe_busy;
    cmd.out_load   = (state == S_FETCH);
    cmd.out_last   = last_item;
    cmd.frame_clr  = out_take && last_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      total <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (in_frame_last) begin
              total <= count + CNT_W'(has_room);
              count <= '0;
              k     <= '0;
              state <= S_SUM;
            end else begin
              count <= count + CNT_W'(has_room);
            end
          end
        end
        S_SUM: begin
          if (last_item) begin
            k     <= '0;
            state <= S_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (stat.root_done) begin
            k     <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_take) begin
            if (last_item) begin
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

/* hdl/coefficient_threshold_and_norm.sv */
// top level: loads a frame at one request per cycle; the first result follows the
// frame's last request after one sum pass over the stored items on the single read
// port, a 4-stage square/accumulate pipe and the square root; the results then go out
// one at a time, each through a fetch and an emit state, and are held while stalled
// synchronous reset empties the frame, clears the largest magnitude and restores
// ratio 0, threshold on, norm over all terms; the coefficient store is not cleared
module coefficient_threshold_and_norm
  import ctn_pkg::*;
#(
  parameter int VORTEX_MAX = VORTEX_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ctn_in_if.sink                in_ch,
  ctn_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = FLUX_TERMS + VORTEX_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  ctn_cmd_t          cmd;
  ctn_stat_t         stat;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  ctn_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_frame_last (in_ch.frame_last),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .cmd           (cmd),
    .stat          (stat),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr)
  );

  ctn_dp #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .in_coeff    (in_ch.coeff_value),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .coeff_out   (out_ch.coeff_out),
    .coeff_index (out_ch.coeff_index),
    .is_flux     (out_ch.is_flux),
    .result_last (out_ch.result_last),
    .norm_value  (out_ch.norm_value)
  );

endmodule

/* hdl/ctn_check.sv */
// port-level checks for the coefficient threshold and norm block
// depends on ctn_pkg; bound to coefficient_threshold_and_norm
module ctn_check
  import ctn_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COEFF_W-1:0] coeff_out,
  input logic [INDEX_W-1:0] coeff_index,
  input logic               is_flux,
  input logic               result_last,
  input logic [ROOT_W-1:0]  norm_value
);

  // held result while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coeff_out) && $stable(coeff_index)
                                && $stable(result_last) && $stable(norm_value))
    else $error("result changed while stalled");

  // no loading while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during emission");

  a_norm_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_last |-> norm_value == '0)
    else $error("norm on non-final result");

  a_flux_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_flux == (coeff_index < INDEX_W'(FLUX_TERMS)))
    else $error("flux flag mismatch");

  a_reload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && result_last |=> in_ready && !out_valid)
    else $error("not back to loading after final result");

endmodule

bind coefficient_threshold_and_norm ctn_check u_check (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .coeff_out   (out_ch.coeff_out),
  .coeff_index (out_ch.coeff_index),
  .is_flux     (out_ch.is_flux),
  .result_last (out_ch.result_last),
  .norm_value  (out_ch.norm_value)
);
